// ===== hw/rtl/mte_pkg.sv =====
// Shared types and constants of the markup tag and entity tokenizer.
`default_nettype none
package mte_pkg;

  localparam int CODE_W  = 32;
  localparam int COUNT_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PAIR_HALF  = 32;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ENTITY = 2'd1,
    KIND_TAG    = 2'd2,
    KIND_QUOTE  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAG_OPEN     = 3'd0,
    REG_TAG_CLOSE    = 3'd1,
    REG_ENTITY_OPEN  = 3'd2,
    REG_ENTITY_CLOSE = 3'd3,
    REG_QUOTE_A      = 3'd4,
    REG_QUOTE_B      = 3'd5,
    REG_MODE_FLAGS   = 3'd6,
    REG_SPARE        = 3'd7
  } reg_index_t;

  localparam logic [CODE_W-1:0] TAG_OPEN_RESET     = 32'd60;
  localparam logic [CODE_W-1:0] TAG_CLOSE_RESET    = 32'd62;
  localparam logic [CODE_W-1:0] ENTITY_OPEN_RESET  = 32'd38;
  localparam logic [CODE_W-1:0] ENTITY_CLOSE_RESET = 32'd59;
  localparam logic [CODE_W-1:0] QUOTE_A_RESET      = 32'd34;
  localparam logic [CODE_W-1:0] QUOTE_B_RESET      = 32'd39;
  localparam logic [2:0]        MODE_FLAGS_RESET   = 3'd3;
  localparam logic [CODE_W-1:0] NEWLINE_CODE       = 32'd10;

  localparam int FLAG_TAGS     = 0;
  localparam int FLAG_ENTITIES = 1;
  localparam int FLAG_LAZY     = 2;

endpackage
`default_nettype wire

// ===== hw/rtl/mte_if.sv =====
// Valid/ready channel interfaces for character input, token output and register writes.
`default_nettype none
interface mte_char_if import mte_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] char_code;
  logic              end_of_stream;
  modport source (output valid, char_code, end_of_stream, input ready);
  modport sink   (input valid, char_code, end_of_stream, output ready);
endinterface

interface mte_token_if import mte_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  char_out;
  logic [1:0]         segment_kind;
  logic               segment_first;
  logic               segment_last;
  logic [COUNT_W-1:0] byte_number;
  logic [COUNT_W-1:0] line_number;
  logic [COUNT_W-1:0] line_start_byte;
  modport source (output valid, char_out, segment_kind, segment_first, segment_last,
                  byte_number, line_number, line_start_byte, input ready);
  modport sink   (input valid, char_out, segment_kind, segment_first, segment_last,
                  byte_number, line_number, line_start_byte, output ready);
endinterface

interface mte_cfg_if import mte_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] reg_data;
  modport source (output valid, reg_index, reg_data, input ready);
  modport sink   (input valid, reg_index, reg_data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/markup_tag_entity_tokenizer_top.sv =====
// Markup tag and entity tokenizer: classifies one character per word into data,
// entity, tag body or quoted tag argument, with segment marks and saturating
// byte, line and line-start positions.
// One character is taken per clock unless the output stalls with the input register
// full. Each word passes an input register, one level of compare and select logic
// against the configured open and close codes, and a result register. The input
// register doubles as a skid stage: one more character is taken while a finished
// token waits at the output. Only the low CHAR_BITS bits of characters and code
// registers take part in compares. Registers are written through the cfg channel,
// which is always ready.
`default_nettype none
module markup_tag_entity_tokenizer_top import mte_pkg::*; #(
  parameter int NUM_QUOTES = 2,
  parameter int CHAR_BITS  = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  mte_char_if.sink      char_in,
  mte_token_if.source   token_out,
  mte_cfg_if.sink       cfg
);

  localparam int QW = (NUM_QUOTES > 1) ? $clog2(NUM_QUOTES) : 1;
  localparam logic [QW-1:0] QI_A = '0;
  localparam logic [QW-1:0] QI_B = QW'(NUM_QUOTES - 1);

  typedef logic [CHAR_BITS-1:0] ch_t;

  ch_t        tag_open, tag_close, entity_open, entity_close;
  ch_t        quote_open  [NUM_QUOTES];
  ch_t        quote_close [NUM_QUOTES];
  logic [2:0] mode_flags;

  kind_t              scan_mode, scan_mode_next;
  logic [QW-1:0]      open_quote_index, open_quote_index_next;
  logic               segment_open, segment_open_next;
  logic [COUNT_W-1:0] byte_counter, line_counter, line_start;

  logic s1_valid;
  ch_t  s1_char;
  logic s1_eos;

  logic out_valid;
  logic advance, take, fire;

  kind_t kind;
  logic  first, last;
  logic  opener_hit;
  logic [QW-1:0] opener_index;

  assign cfg.ready     = 1'b1;
  assign advance       = !out_valid || token_out.ready;
  assign char_in.ready = !s1_valid || advance;
  assign take          = char_in.valid && char_in.ready;
  assign fire          = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_open     <= CHAR_BITS'(TAG_OPEN_RESET);
      tag_close    <= CHAR_BITS'(TAG_CLOSE_RESET);
      entity_open  <= CHAR_BITS'(ENTITY_OPEN_RESET);
      entity_close <= CHAR_BITS'(ENTITY_CLOSE_RESET);
      quote_open[QI_A]  <= CHAR_BITS'(QUOTE_A_RESET);
      quote_close[QI_A] <= CHAR_BITS'(QUOTE_A_RESET);
      if (NUM_QUOTES > 1) begin
        quote_open[QI_B]  <= CHAR_BITS'(QUOTE_B_RESET);
        quote_close[QI_B] <= CHAR_BITS'(QUOTE_B_RESET);
      end
      mode_flags <= MODE_FLAGS_RESET;
    end else if (cfg.valid) begin
      case (reg_index_t'(cfg.reg_index))
        REG_TAG_OPEN:     tag_open     <= CHAR_BITS'(cfg.reg_data);
        REG_TAG_CLOSE:    tag_close    <= CHAR_BITS'(cfg.reg_data);
        REG_ENTITY_OPEN:  entity_open  <= CHAR_BITS'(cfg.reg_data);
        REG_ENTITY_CLOSE: entity_close <= CHAR_BITS'(cfg.reg_data);
        REG_QUOTE_A: begin
          quote_open[QI_A]  <= CHAR_BITS'(cfg.reg_data[PAIR_HALF-1:0]);
          quote_close[QI_A] <= CHAR_BITS'(cfg.reg_data[CFG_DATA_W-1:PAIR_HALF]);
        end
        REG_QUOTE_B: begin
          if (NUM_QUOTES > 1) begin
            quote_open[QI_B]  <= CHAR_BITS'(cfg.reg_data[PAIR_HALF-1:0]);
            quote_close[QI_B] <= CHAR_BITS'(cfg.reg_data[CFG_DATA_W-1:PAIR_HALF]);
          end
        end
        REG_MODE_FLAGS:   mode_flags <= cfg.reg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_char <= CHAR_BITS'(char_in.char_code);
      s1_eos  <= char_in.end_of_stream;
    end
  end

  always_comb begin
    opener_hit   = 1'b0;
    opener_index = QI_A;
    for (int i = NUM_QUOTES - 1; i >= 0; i--) begin
      if (s1_char == quote_open[i]) begin
        opener_hit   = 1'b1;
        opener_index = QW'(i);
      end
    end
  end

  always_comb begin
    kind                  = KIND_DATA;
    first                 = 1'b0;
    last                  = 1'b0;
    scan_mode_next        = scan_mode;
    open_quote_index_next = open_quote_index;
    segment_open_next     = segment_open;
    case (scan_mode)
      KIND_DATA: begin
        if (mode_flags[FLAG_ENTITIES] && s1_char == entity_open) begin
          kind = KIND_ENTITY;
          first = 1'b1;
          scan_mode_next = KIND_ENTITY;
          segment_open_next = 1'b0;
        end else if (mode_flags[FLAG_TAGS] && s1_char == tag_open) begin
          kind = KIND_TAG;
          first = 1'b1;
          scan_mode_next = KIND_TAG;
          segment_open_next = 1'b0;
        end else begin
          first = !segment_open;
          segment_open_next = 1'b1;
        end
      end
      KIND_ENTITY: begin
        kind = KIND_ENTITY;
        if (s1_char == entity_close) begin
          last = 1'b1;
          scan_mode_next = KIND_DATA;
        end
      end
      KIND_TAG: begin
        kind = KIND_TAG;
        if (s1_char == tag_close) begin
          last = 1'b1;
          scan_mode_next = KIND_DATA;
        end else if (opener_hit) begin
          kind = KIND_QUOTE;
          first = 1'b1;
          scan_mode_next = KIND_QUOTE;
          open_quote_index_next = opener_index;
        end
      end
      default: begin
        kind = KIND_QUOTE;
        if (s1_char == quote_close[open_quote_index]) begin
          scan_mode_next = KIND_TAG;
        end else if (mode_flags[FLAG_LAZY] && s1_char == tag_close) begin
          kind = KIND_TAG;
          last = 1'b1;
          scan_mode_next = KIND_DATA;
        end
      end
    endcase
    if (s1_eos) begin
      if (kind != KIND_DATA) begin
        last = 1'b1;
      end
      scan_mode_next    = KIND_DATA;
      segment_open_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode        <= KIND_DATA;
      open_quote_index <= QI_A;
      segment_open     <= 1'b0;
      byte_counter     <= COUNT_W'(1);
      line_counter     <= COUNT_W'(1);
      line_start       <= COUNT_W'(1);
      out_valid        <= 1'b0;
    end else begin
      if (fire) begin
        scan_mode        <= scan_mode_next;
        open_quote_index <= open_quote_index_next;
        segment_open     <= segment_open_next;
        if (byte_counter != '1) begin
          byte_counter <= byte_counter + COUNT_W'(1);
        end
        if (s1_char == CHAR_BITS'(NEWLINE_CODE)) begin
          line_start <= byte_counter;
          if (line_counter != '1) begin
            line_counter <= line_counter + COUNT_W'(1);
          end
        end
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      token_out.char_out        <= CODE_W'(s1_char);
      token_out.segment_kind    <= kind;
      token_out.segment_first   <= first;
      token_out.segment_last    <= last;
      token_out.byte_number     <= byte_counter;
      token_out.line_number     <= line_counter;
      token_out.line_start_byte <= line_start;
    end
  end

  assign token_out.valid = out_valid;

endmodule
`default_nettype wire

// ===== hw/rtl/mte_checker.sv =====
// Port-level checker for the tokenizer and its bind to the top level.
`default_nettype none
module mte_checker import mte_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         segment_kind,
  input wire logic               segment_last,
  input wire logic [COUNT_W-1:0] byte_number,
  input wire logic [COUNT_W-1:0] line_start_byte
);

  logic               seen;
  logic [COUNT_W-1:0] last_byte;
  logic               out_fire;

  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (out_fire) begin
      seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      last_byte <= byte_number;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_number))
    else $error("token word dropped or changed while stalled");

  a_data_no_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && segment_kind == KIND_DATA |-> !segment_last)
    else $error("data character marked as segment end");

  a_line_start: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_start_byte <= byte_number)
    else $error("line start beyond byte number");

  a_byte_step: assert property (@(posedge clk) disable iff (rst)
    out_fire && seen |->
      (byte_number == last_byte + COUNT_W'(1)) || (byte_number == '1 && last_byte == '1))
    else $error("byte number skipped or repeated");

endmodule

bind markup_tag_entity_tokenizer_top mte_checker u_mte_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (token_out.valid),
  .out_ready       (token_out.ready),
  .segment_kind    (token_out.segment_kind),
  .segment_last    (token_out.segment_last),
  .byte_number     (token_out.byte_number),
  .line_start_byte (token_out.line_start_byte)
);
`default_nettype wire

// ===== test/markup_tag_entity_tokenizer_top_tb.sv =====
// Self-checking testbench for the markup tag and entity tokenizer top level.
module markup_tag_entity_tokenizer_top_tb import mte_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_QUOTES = 2;
  localparam int CHAR_BITS  = 32;
  localparam logic [CODE_W-1:0] CHAR_MASK =
    (CHAR_BITS >= 32) ? '1 : CODE_W'((64'd1 << CHAR_BITS) - 64'd1);
  localparam int LONG_HOLD = 80;
  localparam int LIMIT_NS  = 1_000_000;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              eos;
  } char_word_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    kind_t              kind;
    logic               first;
    logic               last;
    logic [COUNT_W-1:0] byte_no;
    logic [COUNT_W-1:0] line_no;
    logic [COUNT_W-1:0] line_begin;
  } token_t;

  logic clk;
  logic rst;

  mte_char_if  char_bus();
  mte_token_if token_bus();
  mte_cfg_if   cfg_bus();

  markup_tag_entity_tokenizer_top #(
    .NUM_QUOTES(NUM_QUOTES),
    .CHAR_BITS (CHAR_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .char_in  (char_bus),
    .token_out(token_bus),
    .cfg      (cfg_bus)
  );

  // register copies
  logic [CODE_W-1:0] tag_open_code, tag_close_code, ent_open_code, ent_close_code;
  logic [63:0]       quote_a_pair, quote_b_pair;
  logic [2:0]        scan_flags;

  // tokenizer state
  kind_t              scan_state;
  logic               quote_sel;
  logic               run_open;
  logic [COUNT_W-1:0] byte_cnt, line_cnt, line_begin_cnt;

  char_word_t pending_chars[$];
  token_t     expected_tokens[$];

  int mismatches = 0;
  int src_gap;
  int sink_wait;
  int sink_draw;
  int hold_left;
  int hold_requests = 0;
  int hold_seen;
  int chars_queued = 0;
  bit src_quiet = 0;
  bit sink_quiet = 0;
  char_word_t offered;

  function automatic logic [CODE_W-1:0] quote_open_code(input logic sel);
    return (sel ? quote_b_pair[31:0] : quote_a_pair[31:0]) & CHAR_MASK;
  endfunction

  function automatic logic [CODE_W-1:0] quote_close_code(input logic sel);
    return (sel ? quote_b_pair[63:32] : quote_a_pair[63:32]) & CHAR_MASK;
  endfunction

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic token_t classify_char(input char_word_t w);
    token_t            t;
    logic [CODE_W-1:0] c;
    c = w.code & CHAR_MASK;
    t.code  = c;
    t.kind  = KIND_DATA;
    t.first = 1'b0;
    t.last  = 1'b0;
    case (scan_state)
      KIND_DATA: begin
        if (scan_flags[FLAG_ENTITIES] && c == (ent_open_code & CHAR_MASK)) begin
          t.kind = KIND_ENTITY; t.first = 1'b1; scan_state = KIND_ENTITY; run_open = 1'b0;
        end else if (scan_flags[FLAG_TAGS] && c == (tag_open_code & CHAR_MASK)) begin
          t.kind = KIND_TAG; t.first = 1'b1; scan_state = KIND_TAG; run_open = 1'b0;
        end else begin
          t.first = !run_open; run_open = 1'b1;
        end
      end
      KIND_ENTITY: begin
        t.kind = KIND_ENTITY;
        if (c == (ent_close_code & CHAR_MASK)) begin
          t.last = 1'b1; scan_state = KIND_DATA;
        end
      end
      KIND_TAG: begin
        t.kind = KIND_TAG;
        if (c == (tag_close_code & CHAR_MASK)) begin
          t.last = 1'b1; scan_state = KIND_DATA;
        end else if (c == quote_open_code(1'b0)) begin
          t.kind = KIND_QUOTE; t.first = 1'b1; scan_state = KIND_QUOTE; quote_sel = 1'b0;
        end else if (NUM_QUOTES > 1 && c == quote_open_code(1'b1)) begin
          t.kind = KIND_QUOTE; t.first = 1'b1; scan_state = KIND_QUOTE; quote_sel = 1'b1;
        end
      end
      default: begin
        t.kind = KIND_QUOTE;
        if (c == quote_close_code(quote_sel)) begin
          scan_state = KIND_TAG;
        end else if (scan_flags[FLAG_LAZY] && c == (tag_close_code & CHAR_MASK)) begin
          t.kind = KIND_TAG; t.last = 1'b1; scan_state = KIND_DATA;
        end
      end
    endcase
    if (w.eos) begin
      if (t.kind != KIND_DATA) t.last = 1'b1;
      scan_state = KIND_DATA;
      run_open   = 1'b0;
    end
    t.byte_no    = byte_cnt;
    t.line_no    = line_cnt;
    t.line_begin = line_begin_cnt;
    if (c == NEWLINE_CODE) begin
      line_begin_cnt = byte_cnt;
      line_cnt       = bump(line_cnt);
    end
    byte_cnt = bump(byte_cnt);
    return t;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_token();
    token_t want;
    if (expected_tokens.size() == 0) begin
      $error("token word arrived with nothing expected");
      mismatches++;
    end else begin
      want = expected_tokens.pop_front();
      check_field("char_out", want.code, token_bus.char_out);
      check_field("segment_kind", 32'(want.kind), 32'(token_bus.segment_kind));
      check_field("segment_first", 32'(want.first), 32'(token_bus.segment_first));
      check_field("segment_last", 32'(want.last), 32'(token_bus.segment_last));
      check_field("byte_number", want.byte_no, token_bus.byte_number);
      check_field("line_number", want.line_no, token_bus.line_number);
      check_field("line_start_byte", want.line_begin, token_bus.line_start_byte);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      char_bus.valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (char_bus.valid && char_bus.ready)
        expected_tokens.push_back(classify_char({char_bus.char_code, char_bus.end_of_stream}));
      if (!char_bus.valid || char_bus.ready) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          char_bus.valid <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          offered = pending_chars.pop_front();
          char_bus.valid <= 1'b1;
          char_bus.char_code <= offered.code;
          char_bus.end_of_stream <= offered.eos;
          src_gap <= src_quiet ? 0 : $urandom_range(0, 14);
        end else begin
          char_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      token_bus.ready <= 1'b0;
      sink_wait <= 0;
      hold_left <= 0;
      hold_seen <= 0;
    end else begin
      if (token_bus.valid && token_bus.ready) check_token();
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        token_bus.ready <= 1'b0;
      end else if (hold_seen != hold_requests) begin
        hold_seen <= hold_requests;
        hold_left <= LONG_HOLD;
        token_bus.ready <= 1'b0;
      end else if (sink_wait != 0) begin
        sink_wait <= sink_wait - 1;
        token_bus.ready <= 1'b0;
      end else if (token_bus.valid && token_bus.ready) begin
        sink_draw = sink_quiet ? 0 : $urandom_range(0, 14);
        if (sink_draw == 0) begin
          token_bus.ready <= 1'b1;
        end else begin
          sink_wait <= sink_draw - 1;
          token_bus.ready <= 1'b0;
        end
      end else begin
        token_bus.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.reg_data <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_TAG_OPEN:     tag_open_code = data[31:0];
      REG_TAG_CLOSE:    tag_close_code = data[31:0];
      REG_ENTITY_OPEN:  ent_open_code = data[31:0];
      REG_ENTITY_CLOSE: ent_close_code = data[31:0];
      REG_QUOTE_A:      quote_a_pair = data;
      REG_QUOTE_B:      quote_b_pair = data;
      REG_MODE_FLAGS:   scan_flags = data[2:0];
      default: ;
    endcase
  endtask

  task automatic program_all(input logic [31:0] t_open, t_close, e_open, e_close,
                             input logic [63:0] qa, qb, input logic [2:0] fl);
    write_reg(REG_TAG_OPEN, 64'(t_open));
    write_reg(REG_TAG_CLOSE, 64'(t_close));
    write_reg(REG_ENTITY_OPEN, 64'(e_open));
    write_reg(REG_ENTITY_CLOSE, 64'(e_close));
    write_reg(REG_QUOTE_A, qa);
    write_reg(REG_QUOTE_B, qb);
    write_reg(REG_MODE_FLAGS, {$urandom, 29'($urandom), fl});
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_chars.size() != 0 || expected_tokens.size() != 0 || char_bus.valid);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_code();
    logic [31:0] alphabet[10] = '{34, 38, 39, 40, 41, 59, 60, 62, 10, 97};
    if ($urandom_range(0, 9) < 7) return alphabet[$urandom_range(0, 9)];
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_plain();
    int r;
    r = $urandom_range(0, 11);
    if (r < 9) return $urandom_range(97, 122);
    if (r < 11) return NEWLINE_CODE;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_char();
    case ($urandom_range(0, 9))
      0: return tag_open_code;
      1: return tag_close_code;
      2: return ent_open_code;
      3: return ent_close_code;
      4: return quote_a_pair[31:0];
      5: return quote_a_pair[63:32];
      6: return quote_b_pair[31:0];
      7: return quote_b_pair[63:32];
      8: return $urandom;
      default: return pick_plain();
    endcase
  endfunction

  function automatic void push_char(input logic [31:0] c, input logic eos);
    pending_chars.push_back({c, eos});
    chars_queued++;
  endfunction

  function automatic void push_stream_char(input logic [31:0] c);
    push_char(c, $urandom_range(0, 39) == 0);
  endfunction

  function automatic void push_plain_run(input int lo, input int hi);
    int n;
    n = $urandom_range(lo, hi);
    repeat (n) push_stream_char(pick_plain());
  endfunction

  function automatic void push_fragment();
    logic sel;
    sel = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1: push_plain_run(1, 5);
      2, 3: begin
        push_stream_char(ent_open_code);
        push_plain_run(0, 3);
        push_stream_char(ent_close_code);
      end
      4, 5, 6: begin
        push_stream_char(tag_open_code);
        push_plain_run(1, 4);
        if ($urandom_range(0, 1)) begin
          push_stream_char(sel ? quote_b_pair[31:0] : quote_a_pair[31:0]);
          push_plain_run(0, 3);
          push_stream_char(sel ? quote_b_pair[63:32] : quote_a_pair[63:32]);
          push_plain_run(0, 2);
        end
        push_stream_char(tag_close_code);
      end
      7: begin
        push_stream_char(tag_open_code);
        push_plain_run(0, 2);
        push_stream_char(sel ? quote_b_pair[31:0] : quote_a_pair[31:0]);
        push_plain_run(0, 2);
        push_stream_char(tag_close_code);
      end
      default: begin
        repeat ($urandom_range(1, 4)) push_stream_char(pick_char());
      end
    endcase
  endfunction

  function automatic void push_fragments(input int count);
    int goal;
    goal = chars_queued + count;
    while (chars_queued < goal) push_fragment();
  endfunction

  initial begin
    logic [2:0] fl;
    rst = 1'b1;
    cfg_bus.valid = 1'b0;
    cfg_bus.reg_index = REG_TAG_OPEN;
    cfg_bus.reg_data = '0;
    tag_open_code  = TAG_OPEN_RESET;
    tag_close_code = TAG_CLOSE_RESET;
    ent_open_code  = ENTITY_OPEN_RESET;
    ent_close_code = ENTITY_CLOSE_RESET;
    quote_a_pair   = {QUOTE_A_RESET, QUOTE_A_RESET};
    quote_b_pair   = {QUOTE_B_RESET, QUOTE_B_RESET};
    scan_flags     = MODE_FLAGS_RESET;
    scan_state     = KIND_DATA;
    quote_sel      = 1'b0;
    run_open       = 1'b0;
    byte_cnt       = 1;
    line_cnt       = 1;
    line_begin_cnt = 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    push_char("a", 1'b0);
    push_char(32'hFFFF_FFFF, 1'b0);
    push_char("&", 1'b0);
    push_char("x", 1'b0);
    push_char(";", 1'b0);
    push_char("<", 1'b0);
    push_char("t", 1'b0);
    push_char("\"", 1'b0);
    push_char(">", 1'b0);
    push_char("\"", 1'b0);
    push_char("'", 1'b0);
    push_char("'", 1'b0);
    push_char(">", 1'b0);
    push_char(NEWLINE_CODE, 1'b0);
    push_char(32'h0, 1'b0);
    push_char("<", 1'b0);
    push_char("z", 1'b1);
    push_char("&", 1'b1);
    push_char("q", 1'b1);
    push_char("r", 1'b0);
    drain();

    // quote closer equal to tag close, then lazy tag end
    write_reg(REG_QUOTE_A, {32'd62, 32'd40});
    write_reg(REG_MODE_FLAGS, 64'd7);
    push_char("<", 1'b0);
    push_char("(", 1'b0);
    push_char("x", 1'b0);
    push_char(">", 1'b0);
    push_char(">", 1'b0);
    push_char("<", 1'b0);
    push_char("'", 1'b0);
    push_char("y", 1'b0);
    push_char(">", 1'b0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      src_quiet  = (ph == 5);
      sink_quiet = (ph == 5);
      if (ph == 0) begin
        program_all('0, '0, '0, '0, '0, '0, 3'd0);
        write_reg(REG_SPARE, {$urandom, $urandom});
      end else if (ph == 1) begin
        program_all('1, '1, '1, '1, '1, '1, 3'd7);
      end else begin
        fl = 3'($urandom_range(0, 7));
        program_all(pick_code(), pick_code(), pick_code(), pick_code(),
                    {pick_code(), pick_code()}, {pick_code(), pick_code()}, fl);
      end
      if (ph == 2) begin
        src_quiet = 1;
        hold_requests++;
        push_fragments(40);
        drain();
        src_quiet = 0;
        push_fragments(35);
      end else if (ph == 3) begin
        push_fragments(35);
        drain();
        push_fragments(40);
      end else begin
        push_fragments(75);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mte_pkg.sv
hw/rtl/mte_if.sv
hw/rtl/markup_tag_entity_tokenizer_top.sv
hw/rtl/mte_checker.sv
test/markup_tag_entity_tokenizer_top_tb.sv
